// ===== rtl/column_projection_segmenter_unit_assert.svh =====
// Assertion macros for the column projection segmenter.
// All properties are sampled on the rising clock edge and are off during reset.
`ifndef COLUMN_PROJECTION_SEGMENTER_UNIT_ASSERT_SVH
`define COLUMN_PROJECTION_SEGMENTER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPSU_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CPSU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cpsu_pkg.sv =====
`default_nettype none

package cpsu_pkg;

   localparam int MASK_W  = 64;
   localparam int COORD_W = 12;
   localparam int OUT_W   = 13;
   localparam int ROWS_W  = 7;
   localparam int ENC_W   = 6;
   localparam int CSR_W   = 2;

   localparam logic [CSR_W-1:0] CSR_BOX_LEFT = 2'd0;
   localparam logic [CSR_W-1:0] CSR_BOX_TOP  = 2'd1;
   localparam logic [CSR_W-1:0] CSR_BOX_ROWS = 2'd2;

   localparam logic [ROWS_W-1:0] BOX_ROWS_RESET = 7'd64;

   typedef struct packed {
      logic [MASK_W-1:0] column_mask;
      logic              last_column;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0]  seg_left;
      logic [OUT_W-1:0]  seg_width;
      logic [OUT_W-1:0]  seg_top;
      logic [ROWS_W-1:0] seg_height;
   } rsp_type;

   // Segment close event from the tracker to the output stage.
   typedef struct packed {
      logic               valid;
      logic [OUT_W-1:0]   width;
      logic [COORD_W-1:0] column;
      logic [MASK_W-1:0]  rows;
   } emit_type;

endpackage

`default_nettype wire

// ===== rtl/column_projection_segmenter_unit.sv =====
// Column projection segmenter: takes one column mask of a box region per
// transaction and reports each run of non-white columns as one result holding
// its left edge, width, and the top and height of its non-white rows. A
// segment closes on the next all-white column or on the column flagged
// last_column; after the last column the block starts a new region. The block
// accepts one column every cycle while the result channel does not stall: a
// column is held in the input register, and its result (if any) is written to
// the output register as the column leaves it, once the output register is
// free. Throughput is limited only by stalls on the result channel. Program
// box_left, box_top and box_rows only while no column is in flight.
`default_nettype none

module column_projection_segmenter_unit #(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLUMNS = 4096
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  cpsu_pkg::req_type          req_payload,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output cpsu_pkg::rsp_type                rsp_payload,
   input  wire                              csr_we,
   input  wire  [cpsu_pkg::CSR_W-1:0]       csr_index,
   input  wire  [cpsu_pkg::COORD_W-1:0]     csr_wdata
);

   localparam logic [cpsu_pkg::ROWS_W-1:0] RowLimit = cpsu_pkg::ROWS_W'(MAX_ROWS);

   logic [cpsu_pkg::COORD_W-1:0] box_left_ff, box_top_ff;
   logic [cpsu_pkg::ROWS_W-1:0]  box_rows_ff;

   logic                         s1_valid_ff;
   cpsu_pkg::req_type            s1_req_ff;
   logic                         rsp_valid_ff;
   cpsu_pkg::rsp_type            rsp_payload_ff, rsp_payload_in;

   logic                         out_free, advance;
   logic [cpsu_pkg::ROWS_W-1:0]  rows_used;
   logic [cpsu_pkg::MASK_W-1:0]  row_mask, mask_clip;
   cpsu_pkg::emit_type           emit;
   logic [cpsu_pkg::ENC_W-1:0]   top_row, bottom_row;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         box_left_ff <= '0;
         box_top_ff  <= '0;
         box_rows_ff <= cpsu_pkg::BOX_ROWS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            cpsu_pkg::CSR_BOX_LEFT: box_left_ff <= csr_wdata;
            cpsu_pkg::CSR_BOX_TOP:  box_top_ff  <= csr_wdata;
            cpsu_pkg::CSR_BOX_ROWS: box_rows_ff <= csr_wdata[cpsu_pkg::ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake: the input register advances whenever the output register is free
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!s1_valid_ff || out_free) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_req_ff <= req_payload;
      end
   end

   // drop mask bits beyond the rows in use
   always_comb begin
      rows_used = (box_rows_ff > RowLimit) ? RowLimit : box_rows_ff;
      for (int r = 0; r < cpsu_pkg::MASK_W; r++) begin
         row_mask[r] = (cpsu_pkg::ROWS_W'(r) < rows_used);
      end
      mask_clip = s1_req_ff.column_mask & row_mask;
   end

   cpsu_tracker #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_tracker (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .mask    (mask_clip),
      .last    (s1_req_ff.last_column),
      .emit    (emit)
   );

   cpsu_extent u_extent (
      .rows   (emit.rows),
      .top    (top_row),
      .bottom (bottom_row)
   );

   always_comb begin
      rsp_payload_in.seg_left   = cpsu_pkg::OUT_W'(box_left_ff) + cpsu_pkg::OUT_W'(emit.column);
      rsp_payload_in.seg_width  = emit.width;
      rsp_payload_in.seg_top    = cpsu_pkg::OUT_W'(box_top_ff) + cpsu_pkg::OUT_W'(top_row);
      rsp_payload_in.seg_height = cpsu_pkg::ROWS_W'(bottom_row) - cpsu_pkg::ROWS_W'(top_row)
                                  + cpsu_pkg::ROWS_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance && emit.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit.valid) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`include "column_projection_segmenter_unit_assert.svh"

   `CPSU_ASSERT_SAME(a_last_dark_emits, advance && s1_req_ff.last_column && (mask_clip != '0),
      emit.valid, "non-white last column produced no segment")
   `CPSU_ASSERT_SAME(a_width_nonzero, rsp_valid_ff, rsp_payload_ff.seg_width != '0,
      "segment width is zero")
   `CPSU_ASSERT_SAME(a_height_range, rsp_valid_ff,
      (rsp_payload_ff.seg_height != '0) && (rsp_payload_ff.seg_height <= RowLimit),
      "segment height out of range")
   `CPSU_ASSERT_NEXT(a_emit_loads_output, advance && emit.valid, rsp_valid_ff,
      "closed segment did not reach the output register")

endmodule

`default_nettype wire

// ===== rtl/cpsu_tracker.sv =====
`default_nettype none

module cpsu_tracker #(
   parameter int MAX_COLUMNS = 4096
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              advance,
   input  wire  [cpsu_pkg::MASK_W-1:0]      mask,
   input  wire                              last,
   output cpsu_pkg::emit_type               emit
);

   localparam int COL_W = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;
   localparam logic [COL_W-1:0] ColLimit = COL_W'(MAX_COLUMNS - 1);

   logic                           segment_open_ff, segment_open_in;
   logic [cpsu_pkg::COORD_W-1:0]   open_column_ff, open_column_in;
   logic [COL_W-1:0]               column_index_ff, column_index_in;
   logic [cpsu_pkg::MASK_W-1:0]    row_union_ff, row_union_in;
   logic                           white;
   logic [cpsu_pkg::OUT_W-1:0]     width_raw;

   always_comb begin
      white           = (mask == '0);
      segment_open_in = segment_open_ff;
      open_column_in  = open_column_ff;
      column_index_in = column_index_ff;
      row_union_in    = row_union_ff;
      emit            = '0;
      width_raw       = '0;

      if (!segment_open_ff) begin
         if (!white) begin
            segment_open_in = 1'b1;
            open_column_in  = cpsu_pkg::COORD_W'(column_index_ff);
            row_union_in    = mask;
         end
      end else if (white) begin
         // close on the white column; it is not part of the segment
         emit.valid      = 1'b1;
         emit.column     = open_column_ff;
         emit.rows       = row_union_ff;
         width_raw       = cpsu_pkg::OUT_W'(column_index_ff) - cpsu_pkg::OUT_W'(open_column_ff);
         segment_open_in = 1'b0;
         row_union_in    = '0;
      end else begin
         row_union_in = row_union_ff | mask;
      end

      if (last) begin
         if (segment_open_in && !emit.valid) begin
            emit.valid  = 1'b1;
            emit.column = open_column_in;
            emit.rows   = row_union_in;
            width_raw   = cpsu_pkg::OUT_W'(column_index_ff) - cpsu_pkg::OUT_W'(open_column_in)
                          + cpsu_pkg::OUT_W'(1);
         end
         segment_open_in = 1'b0;
         open_column_in  = '0;
         column_index_in = '0;
         row_union_in    = '0;
      end else if (column_index_ff < ColLimit) begin
         column_index_in = column_index_ff + COL_W'(1);
      end

      // a zero width only comes from a saturated index
      emit.width = (width_raw == '0) ? cpsu_pkg::OUT_W'(1) : width_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         segment_open_ff <= 1'b0;
         open_column_ff  <= '0;
         column_index_ff <= '0;
         row_union_ff    <= '0;
      end else if (advance) begin
         segment_open_ff <= segment_open_in;
         open_column_ff  <= open_column_in;
         column_index_ff <= column_index_in;
         row_union_ff    <= row_union_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cpsu_extent.sv =====
`default_nettype none

module cpsu_extent (
   input  wire  [cpsu_pkg::MASK_W-1:0] rows,
   output logic [cpsu_pkg::ENC_W-1:0]  top,
   output logic [cpsu_pkg::ENC_W-1:0]  bottom
);

   // Two priority encoders: lowest and highest set row.
   always_comb begin
      top    = '0;
      bottom = '0;
      for (int r = cpsu_pkg::MASK_W - 1; r >= 0; r--) begin
         if (rows[r]) top = cpsu_pkg::ENC_W'(r);
      end
      for (int r = 0; r < cpsu_pkg::MASK_W; r++) begin
         if (rows[r]) bottom = cpsu_pkg::ENC_W'(r);
      end
   end

endmodule

`default_nettype wire
